FILE: src/rgbw_fade_dimmer_macros.svh
// Assertion macros for the checker file of the fade dimmer.
// No dependencies; take it in with a plain include.
`ifndef RGBW_FADE_DIMMER_MACROS_SVH
`define RGBW_FADE_DIMMER_MACROS_SVH

// Clocked property, switched off while reset is high
`define RFD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked property that is also checked during reset
`define RFD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

FILE: src/rfd_pkg.sv
// Package of the RGBW fade dimmer: widths, codes, reset values, helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rfd_pkg;

   // storage and port sizes
   localparam int CHANNELS    = 4;
   localparam int OUT_COLOURS = 4;
   localparam int VALUE_W     = 8;
   localparam int LEVEL_W     = 7;
   localparam int PROD_W      = LEVEL_W + VALUE_W;
   localparam int CNT_W       = 3;
   localparam int TICK_W      = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [LEVEL_W-1:0] MAX_LEVEL   = LEVEL_W'(100);
   localparam logic [LEVEL_W-1:0] RESET_LEVEL = LEVEL_W'(20);

   localparam logic [CNT_W-1:0]   RESET_CHANNEL_COUNT = CNT_W'(4);
   localparam logic [VALUE_W-1:0] RESET_STEP_SIZE     = VALUE_W'(1);
   localparam logic [TICK_W-1:0]  RESET_INTERVAL      = TICK_W'(10);

   // x / 100 == (x * 5243) >> 19 for every x below 43690
   localparam int                 DIV_MUL_W    = 13;
   localparam logic [DIV_MUL_W-1:0] DIV100_MUL = DIV_MUL_W'(5243);
   localparam int                 DIV100_SHIFT = 19;

   typedef enum logic [1:0] {
      FUNC_TICK,
      FUNC_COLOUR,
      FUNC_LEVEL,
      FUNC_SWITCH
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CHANNEL_COUNT,
      REG_STEP_SIZE,
      REG_INTERVAL
   } reg_index_type;

   typedef struct packed {
      logic [CNT_W-1:0]   channel_count;
      logic [VALUE_W-1:0] step_size;
      logic [TICK_W-1:0]  interval_ticks;
   } cfg_type;

   typedef struct packed {
      func_type                             func;
      logic [OUT_COLOURS-1:0][VALUE_W-1:0] color;
      logic [LEVEL_W-1:0]                   level;
      logic                                 switch_on;
   } req_data_type;

   // level * value products for one transaction, plus flags
   typedef struct packed {
      logic [OUT_COLOURS-1:0][PROD_W-1:0] prod;
      logic                               fading;
      logic                               is_on;
   } stage_type;

   // move cur toward goal by step, stopping at goal
   function automatic logic [VALUE_W-1:0] approach(input logic [VALUE_W-1:0] cur,
                                                   input logic [VALUE_W-1:0] goal,
                                                   input logic [VALUE_W-1:0] step);
      logic [VALUE_W-1:0] diff;
      logic [VALUE_W-1:0] res;
      res = cur;
      if (cur < goal) begin
         diff = goal - cur;
         res  = (diff <= step) ? goal : cur + step;
      end else if (cur > goal) begin
         diff = cur - goal;
         res  = (diff <= step) ? goal : cur - step;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: src/rfd_if.sv
// Request and response channel interfaces of the fade dimmer.
// Depends on rfd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rfd_req_if import rfd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic [VALUE_W-1:0] color_0;
   logic [VALUE_W-1:0] color_1;
   logic [VALUE_W-1:0] color_2;
   logic [VALUE_W-1:0] color_3;
   logic [LEVEL_W-1:0] level;
   logic               switch_on;

   modport source (output valid, func, color_0, color_1, color_2, color_3, level,
                   switch_on, input ready);
   modport sink   (input valid, func, color_0, color_1, color_2, color_3, level,
                   switch_on, output ready);
endinterface

interface rfd_rsp_if import rfd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] duty_0;
   logic [VALUE_W-1:0] duty_1;
   logic [VALUE_W-1:0] duty_2;
   logic [VALUE_W-1:0] duty_3;
   logic               fading;
   logic               is_on;

   modport source (output valid, duty_0, duty_1, duty_2, duty_3, fading, is_on,
                   input ready);
   modport sink   (input valid, duty_0, duty_1, duty_2, duty_3, fading, is_on,
                   output ready);
endinterface

`default_nettype wire

FILE: src/rgbw_fade_dimmer.sv
// RGBW fade dimmer top level: an accepted request goes through the stage 1
// register and then the output register before its response is valid; one
// transaction per cycle while the response side is not stalled. Reset
// (synchronous, active high) restores level 20, colours 0, light off, tick
// count 0 and the default registers; both pipeline stages are emptied.
// Depends on rfd_pkg, rfd_if and rfd_core.
`timescale 1ns / 1ps
`default_nettype none

module rgbw_fade_dimmer import rfd_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   rfd_req_if.sink                    req_chan,
   rfd_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type                           cfg_ff;
   req_data_type                      req_data;
   stage_type                         core_result;
   stage_type                         s1_data_ff;
   logic                              s1_valid_ff, s1_valid_in;
   logic                              s1_adv;
   logic                              accept;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [OUT_COLOURS-1:0][VALUE_W-1:0] duty_ff, duty_in;
   logic                              fading_ff;
   logic                              is_on_ff;
   logic [PROD_W+DIV_MUL_W-1:0]       scaled [OUT_COLOURS];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_count  <= RESET_CHANNEL_COUNT;
         cfg_ff.step_size      <= RESET_STEP_SIZE;
         cfg_ff.interval_ticks <= RESET_INTERVAL;
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_CHANNEL_COUNT: cfg_ff.channel_count  <= csr_wdata[CNT_W-1:0];
            REG_STEP_SIZE:     cfg_ff.step_size      <= csr_wdata[VALUE_W-1:0];
            REG_INTERVAL:      cfg_ff.interval_ticks <= csr_wdata[TICK_W-1:0];
            default:           cfg_ff.interval_ticks <= cfg_ff.interval_ticks;
         endcase
      end
   end

   // handshake: stage 1 moves on whenever the output register can take it
   assign s1_adv         = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign accept         = req_chan.valid && req_chan.ready;

   assign req_data.func      = func_type'(req_chan.func);
   assign req_data.color[0]  = req_chan.color_0;
   assign req_data.color[1]  = req_chan.color_1;
   assign req_data.color[2]  = req_chan.color_2;
   assign req_data.color[3]  = req_chan.color_3;
   assign req_data.level     = req_chan.level;
   assign req_data.switch_on = req_chan.switch_on;

   rfd_core u_core (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .result   (core_result)
   );

   // stage 1: products and flags
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_data_ff <= core_result;
      end
   end

   // stage 2: divide by 100 through the reciprocal
   always_comb begin
      for (int i = 0; i < OUT_COLOURS; i++) begin
         scaled[i]  = (PROD_W + DIV_MUL_W)'(s1_data_ff.prod[i]) *
                      (PROD_W + DIV_MUL_W)'(DIV100_MUL);
         duty_in[i] = scaled[i][DIV100_SHIFT +: VALUE_W];
      end
   end

   assign rsp_valid_in = s1_adv ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_valid_ff) begin
         duty_ff   <= duty_in;
         fading_ff <= s1_data_ff.fading;
         is_on_ff  <= s1_data_ff.is_on;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.duty_0 = duty_ff[0];
   assign rsp_chan.duty_1 = duty_ff[1];
   assign rsp_chan.duty_2 = duty_ff[2];
   assign rsp_chan.duty_3 = duty_ff[3];
   assign rsp_chan.fading = fading_ff;
   assign rsp_chan.is_on  = is_on_ff;

endmodule

`default_nettype wire

FILE: src/rfd_core.sv
// Fade state of the dimmer: level, colour values, targets, tick counter.
// Depends on rfd_pkg; produces the level * value products of the new state.
`timescale 1ns / 1ps
`default_nettype none

module rfd_core import rfd_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         accept,
   input  wire req_data_type req_data,
   input  wire cfg_type      cfg,
   output stage_type         result
);

   logic [LEVEL_W-1:0]                cur_level_ff, cur_level_in;
   logic [LEVEL_W-1:0]                goal_level_ff, goal_level_in;
   logic [CHANNELS-1:0][VALUE_W-1:0]  cur_values_ff, cur_values_in;
   logic [CHANNELS-1:0][VALUE_W-1:0]  goal_values_ff, goal_values_in;
   logic                              light_on_ff, light_on_in;
   logic [TICK_W-1:0]                 tick_count_ff, tick_count_in;
   logic [CHANNELS-1:0]               active;
   logic                              do_step;
   logic [LEVEL_W-1:0]                level_goal_now;
   logic [LEVEL_W-1:0]                level_goal_new;
   logic [VALUE_W-1:0]                level_next_wide;

   // channel enables from the configured count
   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         active[i] = (CNT_W + 1)'(i) < {1'b0, cfg.channel_count};
      end
   end

   // event decode and next state
   always_comb begin
      cur_level_in   = cur_level_ff;
      goal_level_in  = goal_level_ff;
      cur_values_in  = cur_values_ff;
      goal_values_in = goal_values_ff;
      light_on_in    = light_on_ff;
      tick_count_in  = tick_count_ff;
      do_step        = 1'b0;
      level_goal_now = light_on_ff ? goal_level_ff : '0;
      level_next_wide = approach({1'b0, cur_level_ff}, {1'b0, level_goal_now},
                                 cfg.step_size);

      case (req_data.func)
         FUNC_TICK: begin
            if (tick_count_ff >= cfg.interval_ticks) begin
               do_step       = 1'b1;
               tick_count_in = '0;
            end else begin
               tick_count_in = tick_count_ff + TICK_W'(1);
            end
         end
         FUNC_COLOUR: begin
            for (int i = 0; i < CHANNELS; i++) begin
               if (i < OUT_COLOURS) begin
                  goal_values_in[i] = req_data.color[i];
               end
            end
         end
         FUNC_LEVEL: begin
            goal_level_in = (req_data.level > MAX_LEVEL) ? MAX_LEVEL : req_data.level;
         end
         FUNC_SWITCH: begin
            light_on_in = req_data.switch_on;
         end
         default: begin
            tick_count_in = tick_count_ff;
         end
      endcase

      // one fade step: level always, colours only while on
      if (do_step) begin
         cur_level_in = level_next_wide[LEVEL_W-1:0];
         for (int i = 0; i < CHANNELS; i++) begin
            if (light_on_ff && active[i]) begin
               cur_values_in[i] = approach(cur_values_ff[i], goal_values_ff[i],
                                           cfg.step_size);
            end
         end
      end
   end

   // result view of the state after this transaction
   always_comb begin
      level_goal_new = light_on_in ? goal_level_in : '0;
      result.fading  = cur_level_in != level_goal_new;
      result.is_on   = light_on_in;
      for (int i = 0; i < CHANNELS; i++) begin
         if (light_on_in && active[i] && (cur_values_in[i] != goal_values_in[i])) begin
            result.fading = 1'b1;
         end
      end
      for (int i = 0; i < OUT_COLOURS; i++) begin
         result.prod[i] = '0;
         if (i < CHANNELS) begin
            if (active[i]) begin
               result.prod[i] = PROD_W'(cur_level_in) * PROD_W'(cur_values_in[i]);
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_level_ff   <= RESET_LEVEL;
         goal_level_ff  <= RESET_LEVEL;
         cur_values_ff  <= '0;
         goal_values_ff <= '0;
         light_on_ff    <= 1'b0;
         tick_count_ff  <= '0;
      end else if (accept) begin
         cur_level_ff   <= cur_level_in;
         goal_level_ff  <= goal_level_in;
         cur_values_ff  <= cur_values_in;
         goal_values_ff <= goal_values_in;
         light_on_ff    <= light_on_in;
         tick_count_ff  <= tick_count_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/rfd_checker.sv
// Port-level checker of the fade dimmer, bound to the top level.
// Depends on rgbw_fade_dimmer_macros.svh and the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
`include "rgbw_fade_dimmer_macros.svh"

module rfd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [33:0] rsp_payload
);

   logic [1:0] outstanding_ff, outstanding_in;
   logic       req_xfer;
   logic       rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   // transactions in flight inside the block
   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_xfer && !rsp_xfer) begin
         outstanding_in = outstanding_ff + 2'd1;
      end else if (rsp_xfer && !req_xfer) begin
         outstanding_in = outstanding_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   `RFD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "stalled response changed")
   `RFD_ASSERT(a_no_phantom, clock, reset, rsp_valid |-> outstanding_ff != 2'd0, "response without a request")
   `RFD_ASSERT(a_depth, clock, reset, outstanding_ff != 2'd3, "more than two transactions in flight")
   `RFD_ASSERT(a_ready_free, clock, reset, !rsp_valid |-> req_ready, "request stalled with output empty")
   `RFD_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid, "response valid after reset")

endmodule

bind rgbw_fade_dimmer rfd_checker u_rfd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload ({rsp_chan.duty_0, rsp_chan.duty_1, rsp_chan.duty_2, rsp_chan.duty_3,
                  rsp_chan.fading, rsp_chan.is_on})
);

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the RGBW fade dimmer: directed and random events
// with random idling on both channels, checked against a behavioural predictor.
// Depends on rfd_pkg, rfd_if and rgbw_fade_dimmer.
`timescale 1ns / 1ps

module tb;
   import rfd_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE = CSR_IDX_W'(3);
   localparam int NUM_SEGMENTS = 12;
   localparam int DRAIN_LIMIT  = 2000;
   localparam int PIPE_SLACK   = 4;

   typedef struct packed {
      logic [OUT_COLOURS-1:0][VALUE_W-1:0] duty;
      logic                                fading;
      logic                                is_on;
   } light_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rfd_req_if req_bus ();
   rfd_rsp_if rsp_bus ();

   rgbw_fade_dimmer dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state and its copy of the registers
   logic [CNT_W-1:0]                    cfg_count;
   logic [VALUE_W-1:0]                  cfg_step;
   logic [TICK_W-1:0]                   cfg_interval;
   logic [LEVEL_W-1:0]                  lvl_now;
   logic [LEVEL_W-1:0]                  lvl_goal;
   logic [OUT_COLOURS-1:0][VALUE_W-1:0] val_now;
   logic [OUT_COLOURS-1:0][VALUE_W-1:0] val_goal;
   logic                                lamp_on;
   logic [TICK_W-1:0]                   tick_cnt;

   light_out_type pending_outputs[$];
   int err_count       = 0;
   int events_sent     = 0;
   int outputs_checked = 0;
   int reg_writes      = 0;
   int gap_pct         = 0;
   int stall_pct       = 0;

   // one fade step of size stride, clamped at the target
   function automatic logic [VALUE_W-1:0] move_toward(input logic [VALUE_W-1:0] from_v,
                                                      input logic [VALUE_W-1:0] to_v,
                                                      input logic [VALUE_W-1:0] stride);
      int delta;
      delta = int'(to_v) - int'(from_v);
      if (delta > int'(stride))
         return from_v + stride;
      if (delta < -int'(stride))
         return from_v - stride;
      return to_v;
   endfunction

   // update the light state for one event and work out the outputs it yields
   function automatic light_out_type apply_event(input req_data_type ev);
      light_out_type      res;
      int                 lit;
      logic [LEVEL_W-1:0] lvl_target;
      case (ev.func)
         FUNC_TICK: begin
            if (tick_cnt >= cfg_interval) begin
               tick_cnt = '0;
               lvl_now  = LEVEL_W'(move_toward(VALUE_W'(lvl_now),
                                               lamp_on ? VALUE_W'(lvl_goal) : '0, cfg_step));
               if (lamp_on)
                  for (int i = 0; i < OUT_COLOURS; i++)
                     if (i < cfg_count)
                        val_now[i] = move_toward(val_now[i], val_goal[i], cfg_step);
            end else begin
               tick_cnt = tick_cnt + 1'b1;
            end
         end
         FUNC_COLOUR: val_goal = ev.color;
         FUNC_LEVEL:  lvl_goal = (ev.level > MAX_LEVEL) ? MAX_LEVEL : ev.level;
         FUNC_SWITCH: lamp_on  = ev.switch_on;
      endcase

      lit        = (cfg_count > CHANNELS) ? CHANNELS : int'(cfg_count);
      lvl_target = lamp_on ? lvl_goal : '0;
      res.fading = (lvl_now != lvl_target);
      res.is_on  = lamp_on;
      for (int i = 0; i < OUT_COLOURS; i++) begin
         res.duty[i] = '0;
         if (i < lit) begin
            res.duty[i] = VALUE_W'((int'(lvl_now) * int'(val_now[i])) / int'(MAX_LEVEL));
            if (lamp_on && val_now[i] != val_goal[i])
               res.fading = 1'b1;
         end
      end
      return res;
   endfunction

   function automatic req_data_type make_event(input func_type f, input logic [31:0] colours,
                                               input logic [LEVEL_W-1:0] lvl, input logic sw);
      req_data_type ev;
      ev.func      = f;
      ev.color     = colours;
      ev.level     = lvl;
      ev.switch_on = sw;
      return ev;
   endfunction

   // mostly ticks, so that fades make progress; fields not used by func stay random
   function automatic req_data_type random_event();
      req_data_type ev;
      int           pick;
      pick         = $urandom_range(99);
      ev.color     = $urandom;
      ev.level     = LEVEL_W'($urandom_range(127));
      ev.switch_on = ($urandom_range(3) != 0);
      if (pick < 65)
         ev.func = FUNC_TICK;
      else if (pick < 80)
         ev.func = FUNC_COLOUR;
      else if (pick < 92)
         ev.func = FUNC_LEVEL;
      else
         ev.func = FUNC_SWITCH;
      return ev;
   endfunction

   // present one event, wait for the transaction, then record its outputs
   task automatic send_event(input req_data_type ev);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid     = 1'b1;
      req_bus.func      = ev.func;
      req_bus.color_0   = ev.color[0];
      req_bus.color_1   = ev.color[1];
      req_bus.color_2   = ev.color[2];
      req_bus.color_3   = ev.color[3];
      req_bus.level     = ev.level;
      req_bus.switch_on = ev.switch_on;
      do
         @(posedge clock);
      while (!req_bus.ready);
      pending_outputs.push_back(apply_event(ev));
      events_sent++;
   endtask

   // stop sending and wait for every outstanding output, then let the pipe empty
   task automatic settle_outputs();
      int waited;
      waited = 0;
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_outputs.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_outputs.size() != 0) begin
         $display("%0t: %0d expected outputs never arrived", $time, pending_outputs.size());
         err_count++;
         pending_outputs.delete();
      end
      repeat (PIPE_SLACK) @(posedge clock);
   endtask

   // register write; only called with the block idle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         REG_CHANNEL_COUNT: cfg_count    = v[CNT_W-1:0];
         REG_STEP_SIZE:     cfg_step     = v;
         REG_INTERVAL:      cfg_interval = v;
         default: ;
      endcase
      reg_writes++;
   endtask

   // response side: random stalls, checked at each rising edge
   always @(negedge clock)
      rsp_bus.ready = ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin : check_outputs
      light_out_type got;
      light_out_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.duty[0] = rsp_bus.duty_0;
         got.duty[1] = rsp_bus.duty_1;
         got.duty[2] = rsp_bus.duty_2;
         got.duty[3] = rsp_bus.duty_3;
         got.fading  = rsp_bus.fading;
         got.is_on   = rsp_bus.is_on;
         if (pending_outputs.size() == 0) begin
            $display("%0t: unexpected output, expected none, got %h", $time, got);
            err_count++;
         end else begin
            want = pending_outputs.pop_front();
            outputs_checked++;
            for (int i = 0; i < OUT_COLOURS; i++)
               if (got.duty[i] !== want.duty[i]) begin
                  $display("%0t: duty_%0d expected %0d, got %0d",
                           $time, i, want.duty[i], got.duty[i]);
                  err_count++;
               end
            if (got.fading !== want.fading) begin
               $display("%0t: fading expected %b, got %b", $time, want.fading, got.fading);
               err_count++;
            end
            if (got.is_on !== want.is_on) begin
               $display("%0t: is_on expected %b, got %b", $time, want.is_on, got.is_on);
               err_count++;
            end
         end
      end
   end

   // from reset: ticks below the interval, target writes, level saturation
   task automatic test_reset_and_targets();
      send_event(make_event(FUNC_TICK,   32'h0000_0000, 7'd0,   1'b0));
      send_event(make_event(FUNC_COLOUR, 32'h55AA_00FF, 7'd127, 1'b0));
      send_event(make_event(FUNC_LEVEL,  32'hFFFF_FFFF, 7'd127, 1'b1));
      send_event(make_event(FUNC_LEVEL,  32'h0000_0000, 7'd100, 1'b0));
      send_event(make_event(FUNC_SWITCH, 32'h0000_0000, 7'd0,   1'b1));
      send_event(make_event(FUNC_TICK,   32'h1234_5678, 7'd55,  1'b0));
      send_event(make_event(FUNC_TICK,   32'h0000_0000, 7'd0,   1'b1));
      settle_outputs();
   endtask

   // big steps clamp at the target; channel count of zero and above the limit
   task automatic test_fast_fade_and_channel_limits();
      write_reg(REG_INTERVAL, 8'd1);
      write_reg(REG_STEP_SIZE, 8'd255);
      send_event(make_event(FUNC_TICK, 32'h0, 7'd0, 1'b0));
      send_event(make_event(FUNC_TICK, 32'h0, 7'd0, 1'b0));
      settle_outputs();
      // upper bits of the count are dropped by the register
      write_reg(REG_CHANNEL_COUNT, 8'hF8);
      send_event(make_event(FUNC_TICK,   32'h0, 7'd0, 1'b0));
      send_event(make_event(FUNC_COLOUR, 32'h0155_FF00, 7'd0, 1'b0));
      settle_outputs();
      write_reg(REG_CHANNEL_COUNT, 8'h07);
      send_event(make_event(FUNC_TICK, 32'h0, 7'd0, 1'b0));
      settle_outputs();
   endtask

   // a zero step leaves everything where it is, fading stays set
   task automatic test_zero_step();
      write_reg(REG_STEP_SIZE, 8'd0);
      send_event(make_event(FUNC_TICK, 32'h0, 7'd0, 1'b0));
      send_event(make_event(FUNC_TICK, 32'h0, 7'd0, 1'b0));
      settle_outputs();
   endtask

   // switching off fades the level to zero while the colours hold
   task automatic test_switch_off_fade();
      write_reg(REG_STEP_SIZE, 8'd1);
      write_reg(REG_INTERVAL, 8'd0);
      write_reg(REG_SPARE, 8'hA5);
      send_event(make_event(FUNC_LEVEL,  32'h0, 7'd0,   1'b0));
      send_event(make_event(FUNC_TICK,   32'h0, 7'd0,   1'b0));
      send_event(make_event(FUNC_SWITCH, 32'h0, 7'd0,   1'b0));
      send_event(make_event(FUNC_TICK,   32'h0, 7'd0,   1'b0));
      send_event(make_event(FUNC_TICK,   32'h0, 7'd0,   1'b0));
      send_event(make_event(FUNC_LEVEL,  32'h0, 7'd101, 1'b0));
      send_event(make_event(FUNC_SWITCH, 32'h0, 7'd0,   1'b1));
      send_event(make_event(FUNC_TICK,   32'h0, 7'd0,   1'b0));
      settle_outputs();
   endtask

   // random events over a range of register settings and idling patterns
   task automatic test_random_traffic();
      logic [CNT_W-1:0]   count_set [NUM_SEGMENTS] = '{4, 1, 4, 7, 2, 3, 5, 0, 1, 4, 6, 3};
      logic [VALUE_W-1:0] step_set  [NUM_SEGMENTS] =
         '{1, 255, 9, 3, 17, 128, 0, 2, 5, 255, 64, 7};
      logic [TICK_W-1:0]  ival_set  [NUM_SEGMENTS] = '{0, 3, 255, 1, 0, 2, 0, 5, 1, 0, 4, 0};
      int                 seg_len;
      for (int s = 0; s < NUM_SEGMENTS; s++) begin
         settle_outputs();
         case (s % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 47; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 47; end
            default: begin gap_pct = 33; stall_pct = 33; end
         endcase
         write_reg(REG_CHANNEL_COUNT, {(CSR_DATA_W-CNT_W)'($urandom), count_set[s]});
         write_reg(REG_STEP_SIZE, step_set[s]);
         write_reg(REG_INTERVAL, ival_set[s]);
         // the longest interval needs a long run of ticks to step at all
         seg_len = (ival_set[s] == 8'd255) ? 420 : 45;
         for (int k = 0; k < seg_len; k++)
            send_event(random_event());
      end
   endtask

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.func      = FUNC_TICK;
      req_bus.color_0   = '0;
      req_bus.color_1   = '0;
      req_bus.color_2   = '0;
      req_bus.color_3   = '0;
      req_bus.level     = '0;
      req_bus.switch_on = 1'b0;
      rsp_bus.ready     = 1'b1;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;

      cfg_count    = RESET_CHANNEL_COUNT;
      cfg_step     = RESET_STEP_SIZE;
      cfg_interval = RESET_INTERVAL;
      lvl_now      = RESET_LEVEL;
      lvl_goal     = RESET_LEVEL;
      val_now      = '0;
      val_goal     = '0;
      lamp_on      = 1'b0;
      tick_cnt     = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_and_targets();
      test_fast_fade_and_channel_limits();
      test_zero_step();
      test_switch_off_fade();
      test_random_traffic();
      settle_outputs();

      $display("Ran %0d events, checked %0d outputs, %0d register writes",
               events_sent, outputs_checked, reg_writes);
      $display("Idling phases: none, sender gaps, receiver stalls, both");
      if (err_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
